// File: rtl/edfs_pkg.sv
// ----------------------------------------------------------------------------
// edfs_pkg
// shared types, codes and helpers for the edf task scheduler
// ----------------------------------------------------------------------------
package edfs_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int MS_PER_SEC    = 1000;
    localparam int SEC_W         = 32;
    localparam int MSEC_W        = 10;
    localparam int CNT_W         = 32;

    // time key, seconds then milliseconds
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [MSEC_W-1:0] msec;
    } time_key_t;

    typedef enum logic [1:0] {
        OP_CREATE_RT = 2'd0,
        OP_CREATE_BG = 2'd1,
        OP_TICK      = 2'd2,
        OP_SELECT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_SEL   = 3'd2,
        ST_WAIT  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // a < b, seconds first
    function automatic logic key_lt(time_key_t a, time_key_t b);
        logic r;
        if (a.sec != b.sec)
            r = (a.sec < b.sec);
        else
            r = (a.msec < b.msec);
        return r;
    endfunction

endpackage

// File: rtl/edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// edf_task_scheduler
// earliest-deadline-first scheduler with linked ready, pending and fifo lists
// ----------------------------------------------------------------------------
// channel  | dir | tuser        | tdata (lowest bit first)
// s_axis   | in  | op (2)       | start_sec, start_msec, rel_deadline_sec,
//          |     |              | rel_deadline_msec, current_ended, zero pad
// m_axis   | out | status (3)   | task_slot, missed_count, met_count, zero pad
//
// one item at a time; a small sequencer walks the lists through a slot store
// with one registered read port, so each list step reads the store and then
// uses the registered data; tick advances time by one millisecond; create scans
// for the lowest free slot, then walks the target list; select releases pending
// tasks, retires or requeues the running task and then dispatches
// reset clears all list heads, the slot in-use bits, time and counters
// s_axis_tready is low while an item is in work or its result is unread
// ----------------------------------------------------------------------------
module edf_task_scheduler #(
    parameter int NUM_TASKS = edfs_pkg::NUM_TASKS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,  // op
    input  logic [87:0]  s_axis_tdata,  // start_sec, start_msec, rel_deadline_sec,
                                        // rel_deadline_msec, current_ended
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [2:0]   m_axis_tuser,  // status
    output logic [((($clog2(NUM_TASKS)+64)+7)/8)*8-1:0] m_axis_tdata
                                        // task_slot, missed_count, met_count
);

    localparam int TW    = $clog2(NUM_TASKS);
    localparam int OUT_W = (((TW + 64) + 7) / 8) * 8;
    localparam logic [TW:0]   NONE  = (TW+1)'(NUM_TASKS);
    localparam logic [TW-1:0] LAST  = TW'(NUM_TASKS - 1);
    localparam logic [10:0]   K1000 = 11'(edfs_pkg::MS_PER_SEC);
    localparam logic [10:0]   K2000 = 11'(2 * edfs_pkg::MS_PER_SEC);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b00000000000000001,
        S_ALLOC  = 17'b00000000000000010,
        S_FPUSH  = 17'b00000000000000100,
        S_FLINK  = 17'b00000000000001000,
        S_INS0   = 17'b00000000000010000,
        S_INS1   = 17'b00000000000100000,
        S_WALK   = 17'b00000000001000000,
        S_WALKRD = 17'b00000000010000000,
        S_LINK2  = 17'b00000000100000000,
        S_REL0   = 17'b00000001000000000,
        S_REL1   = 17'b00000010000000000,
        S_RET0   = 17'b00000100000000000,
        S_RET1   = 17'b00001000000000000,
        S_DISP   = 17'b00010000000000000,
        S_DISPR  = 17'b00100000000000000,
        S_DISPF  = 17'b01000000000000000,
        S_TICK   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    edfs_pkg::op_t      op_reg, op_next;
    logic [87:0]        in_reg, in_next;
    edfs_pkg::time_key_t now_reg, now_next;
    logic [NUM_TASKS-1:0] used_reg, used_next;
    logic [TW:0] ready_head_reg, ready_head_next;
    logic [TW:0] pend_head_reg, pend_head_next;
    logic [TW:0] fifo_head_reg, fifo_head_next;
    logic [TW:0] fifo_tail_reg, fifo_tail_next;
    logic [TW:0] run_reg, run_next;
    logic [edfs_pkg::CNT_W-1:0] missed_reg, missed_next;
    logic [edfs_pkg::CNT_W-1:0] met_reg, met_next;
    logic [TW-1:0] slot_reg, slot_next;      // slot being queued
    logic [TW-1:0] cur_reg, cur_next;
    logic [TW:0]   nx_reg, nx_next;
    logic [TW-1:0] scan_reg, scan_next;
    edfs_pkg::time_key_t skey_reg, skey_next;
    logic          to_ready_reg, to_ready_next; // 1 ready list, 0 pending list
    logic          ovalid_reg, ovalid_next;
    edfs_pkg::status_t status_reg, status_next;
    logic [TW-1:0] oslot_reg, oslot_next;

    // slot store ports
    logic [TW-1:0]       rd_addr;
    logic                key_we, rt_wd, link_we;
    logic [TW-1:0]       key_wa, link_wa;
    logic [TW:0]         link_wd;
    edfs_pkg::time_key_t start_wd, dl_wd, start_q, dl_q;
    logic                rt_q;
    logic [TW:0]         link_q;

    edfs_slot_mem #(.NUM_TASKS(NUM_TASKS)) u_mem (
        .clk         (clk),
        .rd_addr     (rd_addr),
        .key_we      (key_we),
        .key_waddr   (key_wa),
        .start_wdata (start_wd),
        .dl_wdata    (dl_wd),
        .rt_wdata    (rt_wd),
        .link_we     (link_we),
        .link_waddr  (link_wa),
        .link_wdata  (link_wd),
        .start_q     (start_q),
        .dl_q        (dl_q),
        .rt_q        (rt_q),
        .link_q      (link_q)
    );

    // latched item fields
    edfs_pkg::time_key_t in_start;
    logic [31:0] in_rel_sec;
    logic [9:0]  in_rel_msec;
    logic        in_ended;
    logic [10:0] msum;
    logic [1:0]  mcarry;
    logic [10:0] mrem;
    edfs_pkg::time_key_t in_dl;
    logic [TW:0] head_sel;

    assign in_start.sec  = in_reg[31:0];
    assign in_start.msec = in_reg[41:32];
    assign in_rel_sec    = in_reg[73:42];
    assign in_rel_msec   = in_reg[83:74];
    assign in_ended      = in_reg[84];

    // deadline = start + relative, millisecond sum may carry up to two
    always_comb
    begin
        msum = {1'b0, in_start.msec} + {1'b0, in_rel_msec};
        if (msum >= K2000)
        begin
            mcarry = 2'd2;
            mrem   = msum - K2000;
        end
        else if (msum >= K1000)
        begin
            mcarry = 2'd1;
            mrem   = msum - K1000;
        end
        else
        begin
            mcarry = 2'd0;
            mrem   = msum;
        end
        in_dl.sec  = in_start.sec + in_rel_sec + {30'd0, mcarry};
        in_dl.msec = mrem[9:0];
    end

    assign head_sel = to_ready_reg ? ready_head_reg : pend_head_reg;

    // read address for the store, data shows up in the following state
    always_comb
    begin
        unique case (state_reg)
            S_INS0:  rd_addr = head_sel[TW-1:0];
            S_WALK:  rd_addr = nx_reg[TW-1:0];
            S_REL0:  rd_addr = pend_head_reg[TW-1:0];
            S_RET0:  rd_addr = run_reg[TW-1:0];
            S_DISP:  rd_addr = (ready_head_reg != NONE) ? ready_head_reg[TW-1:0]
                                                        : fifo_head_reg[TW-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        in_next        = in_reg;
        now_next       = now_reg;
        used_next      = used_reg;
        ready_head_next = ready_head_reg;
        pend_head_next = pend_head_reg;
        fifo_head_next = fifo_head_reg;
        fifo_tail_next = fifo_tail_reg;
        run_next       = run_reg;
        missed_next    = missed_reg;
        met_next       = met_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        scan_next      = scan_reg;
        skey_next      = skey_reg;
        to_ready_next  = to_ready_reg;
        ovalid_next    = ovalid_reg;
        status_next    = status_reg;
        oslot_next     = oslot_reg;
        key_we   = 1'b0;
        key_wa   = slot_reg;
        start_wd = in_start;
        dl_wd    = in_dl;
        rt_wd    = 1'b0;
        link_we  = 1'b0;
        link_wa  = slot_reg;
        link_wd  = NONE;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && !ovalid_reg)
                begin
                    op_next    = edfs_pkg::op_t'(s_axis_tuser);
                    in_next    = s_axis_tdata;
                    scan_next  = '0;
                    status_next = edfs_pkg::ST_OK;
                    oslot_next = '0;
                    unique case (edfs_pkg::op_t'(s_axis_tuser))
                        edfs_pkg::OP_CREATE_RT, edfs_pkg::OP_CREATE_BG:
                            state_next = S_ALLOC;
                        edfs_pkg::OP_TICK:
                            state_next = S_TICK;
                        edfs_pkg::OP_SELECT:
                            state_next = S_REL0;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            S_TICK:
            begin
                if ({1'b0, now_reg.msec} + 11'd1 >= K1000)
                begin
                    now_next.msec = '0;
                    now_next.sec  = now_reg.sec + 32'd1;
                end
                else
                    now_next.msec = now_reg.msec + 10'd1;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end

            // lowest free slot, one slot per cycle
            S_ALLOC:
            begin
                if (!used_reg[scan_reg])
                begin
                    used_next[scan_reg] = 1'b1;
                    slot_next  = scan_reg;
                    oslot_next = scan_reg;
                    ret_next   = S_IDLE;
                    key_we     = 1'b1;
                    key_wa     = scan_reg;
                    if (op_reg == edfs_pkg::OP_CREATE_RT)
                    begin
                        rt_wd = 1'b1;
                        if (!edfs_pkg::key_lt(now_reg, in_start))
                        begin
                            to_ready_next = 1'b1;
                            skey_next     = in_dl;
                        end
                        else
                        begin
                            to_ready_next = 1'b0;
                            skey_next     = in_start;
                        end
                        state_next = S_INS0;
                    end
                    else
                        state_next = S_FPUSH;
                end
                else if (scan_reg == LAST)
                begin
                    status_next = edfs_pkg::ST_FULL;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    scan_next = scan_reg + TW'(1);
            end

            S_FPUSH:
            begin
                link_we = 1'b1;
                link_wd = NONE;
                state_next = S_FLINK;
            end

            S_FLINK:
            begin
                if (fifo_tail_reg == NONE)
                    fifo_head_next = {1'b0, slot_reg};
                else
                begin
                    link_we = 1'b1;
                    link_wa = fifo_tail_reg[TW-1:0];
                    link_wd = {1'b0, slot_reg};
                end
                fifo_tail_next = {1'b0, slot_reg};
                state_next = ret_reg;
                if (ret_reg == S_IDLE)
                    ovalid_next = 1'b1;
            end

            // sorted insert: head check
            S_INS0:
            begin
                if (head_sel == NONE)
                begin
                    link_we = 1'b1;
                    link_wd = NONE;
                    if (to_ready_reg)
                        ready_head_next = {1'b0, slot_reg};
                    else
                        pend_head_next = {1'b0, slot_reg};
                    state_next = ret_reg;
                    if (ret_reg == S_IDLE)
                        ovalid_next = 1'b1;
                end
                else
                    state_next = S_INS1;
            end

            S_INS1:
            begin
                if (edfs_pkg::key_lt(skey_reg, to_ready_reg ? dl_q : start_q))
                begin
                    link_we = 1'b1;
                    link_wd = head_sel;
                    if (to_ready_reg)
                        ready_head_next = {1'b0, slot_reg};
                    else
                        pend_head_next = {1'b0, slot_reg};
                    state_next = ret_reg;
                    if (ret_reg == S_IDLE)
                        ovalid_next = 1'b1;
                end
                else
                begin
                    cur_next   = head_sel[TW-1:0];
                    nx_next    = link_q;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (nx_reg == NONE)
                begin
                    link_we    = 1'b1;
                    link_wd    = NONE;
                    state_next = S_LINK2;
                end
                else
                    state_next = S_WALKRD;
            end

            S_WALKRD:
            begin
                if (!edfs_pkg::key_lt(to_ready_reg ? dl_q : start_q, skey_reg))
                begin
                    link_we    = 1'b1;
                    link_wd    = nx_reg;
                    state_next = S_LINK2;
                end
                else
                begin
                    cur_next   = nx_reg[TW-1:0];
                    nx_next    = link_q;
                    state_next = S_WALK;
                end
            end

            S_LINK2:
            begin
                link_we = 1'b1;
                link_wa = cur_reg;
                link_wd = {1'b0, slot_reg};
                state_next = ret_reg;
                if (ret_reg == S_IDLE)
                    ovalid_next = 1'b1;
            end

            // move released pending tasks to the ready list
            S_REL0:
            begin
                if (pend_head_reg == NONE)
                    state_next = S_RET0;
                else
                    state_next = S_REL1;
            end

            S_REL1:
            begin
                if (!edfs_pkg::key_lt(now_reg, start_q))
                begin
                    slot_next      = pend_head_reg[TW-1:0];
                    pend_head_next = link_q;
                    skey_next      = dl_q;
                    to_ready_next  = 1'b1;
                    ret_next       = S_REL0;
                    state_next     = S_INS0;
                end
                else
                    state_next = S_RET0;
            end

            // retire or requeue the running task
            S_RET0:
            begin
                if (run_reg == NONE)
                    state_next = S_DISP;
                else
                    state_next = S_RET1;
            end

            S_RET1:
            begin
                slot_next = run_reg[TW-1:0];
                ret_next  = S_DISP;
                if (in_ended)
                begin
                    if (rt_q)
                    begin
                        if (!edfs_pkg::key_lt(now_reg, dl_q))
                            missed_next = missed_reg + 32'd1;
                        else
                            met_next = met_reg + 32'd1;
                    end
                    used_next[run_reg[TW-1:0]] = 1'b0;
                    // slot is free, so nothing runs any more
                    run_next   = NONE;
                    state_next = S_DISP;
                end
                else if (rt_q)
                begin
                    if (!edfs_pkg::key_lt(now_reg, start_q))
                    begin
                        to_ready_next = 1'b1;
                        skey_next     = dl_q;
                    end
                    else
                    begin
                        to_ready_next = 1'b0;
                        skey_next     = start_q;
                    end
                    state_next = S_INS0;
                end
                else
                    state_next = S_FPUSH;
            end

            S_DISP:
            begin
                run_next = NONE;
                if (ready_head_reg != NONE)
                    state_next = S_DISPR;
                else if (fifo_head_reg != NONE)
                    state_next = S_DISPF;
                else
                begin
                    status_next = (pend_head_reg != NONE) ? edfs_pkg::ST_WAIT
                                                          : edfs_pkg::ST_EMPTY;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_DISPR:
            begin
                run_next        = ready_head_reg;
                ready_head_next = link_q;
                status_next     = edfs_pkg::ST_SEL;
                oslot_next      = ready_head_reg[TW-1:0];
                ovalid_next     = 1'b1;
                state_next      = S_IDLE;
            end

            S_DISPF:
            begin
                run_next       = fifo_head_reg;
                fifo_head_next = link_q;
                if (link_q == NONE)
                    fifo_tail_next = NONE;
                status_next    = edfs_pkg::ST_SEL;
                oslot_next     = fifo_head_reg[TW-1:0];
                ovalid_next    = 1'b1;
                state_next     = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            now_reg        <= '0;
            used_reg       <= '0;
            ready_head_reg <= NONE;
            pend_head_reg  <= NONE;
            fifo_head_reg  <= NONE;
            fifo_tail_reg  <= NONE;
            run_reg        <= NONE;
            missed_reg     <= '0;
            met_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            now_reg        <= now_next;
            used_reg       <= used_next;
            ready_head_reg <= ready_head_next;
            pend_head_reg  <= pend_head_next;
            fifo_head_reg  <= fifo_head_next;
            fifo_tail_reg  <= fifo_tail_next;
            run_reg        <= run_next;
            missed_reg     <= missed_next;
            met_reg        <= met_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        in_reg       <= in_next;
        slot_reg     <= slot_next;
        cur_reg      <= cur_next;
        nx_reg       <= nx_next;
        scan_reg     <= scan_next;
        skey_reg     <= skey_next;
        to_ready_reg <= to_ready_next;
        status_reg   <= status_next;
        oslot_reg    <= oslot_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = OUT_W'({met_reg, missed_reg, oslot_reg});

    // a pending result means the sequencer is parked
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> state_reg == S_IDLE)
        else $error("result pending while sequencer busy");

    // fifo head and tail are empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_head_reg == NONE) == (fifo_tail_reg == NONE))
        else $error("fifo head and tail disagree");

    // the running task always holds its slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg != NONE) |-> used_reg[run_reg[TW-1:0]])
        else $error("running task on a free slot");

    // a dispatched task is reported on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPR || state_reg == S_DISPF) |=>
            (ovalid_reg && status_reg == edfs_pkg::ST_SEL))
        else $error("dispatch without selected result");

endmodule

// File: rtl/edfs_slot_mem.sv
// ----------------------------------------------------------------------------
// edfs_slot_mem
// per-slot store: start and deadline keys, kind flag and list link
// ----------------------------------------------------------------------------
module edfs_slot_mem #(
    parameter int NUM_TASKS = edfs_pkg::NUM_TASKS_DEF
) (
    input  logic                         clk,
    input  logic [$clog2(NUM_TASKS)-1:0] rd_addr,
    input  logic                         key_we,
    input  logic [$clog2(NUM_TASKS)-1:0] key_waddr,
    input  edfs_pkg::time_key_t          start_wdata,
    input  edfs_pkg::time_key_t          dl_wdata,
    input  logic                         rt_wdata,
    input  logic                         link_we,
    input  logic [$clog2(NUM_TASKS)-1:0] link_waddr,
    input  logic [$clog2(NUM_TASKS):0]   link_wdata,
    output edfs_pkg::time_key_t          start_q,
    output edfs_pkg::time_key_t          dl_q,
    output logic                         rt_q,
    output logic [$clog2(NUM_TASKS):0]   link_q
);

    localparam int TW = $clog2(NUM_TASKS);

    edfs_pkg::time_key_t start_mem [NUM_TASKS];
    edfs_pkg::time_key_t dl_mem    [NUM_TASKS];
    logic                rt_mem    [NUM_TASKS];
    logic [TW:0]         link_mem  [NUM_TASKS];

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            start_mem[key_waddr] <= start_wdata;
            dl_mem[key_waddr]    <= dl_wdata;
            rt_mem[key_waddr]    <= rt_wdata;
        end
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        start_q <= start_mem[rd_addr];
        dl_q    <= dl_mem[rd_addr];
        rt_q    <= rt_mem[rd_addr];
        link_q  <= link_mem[rd_addr];
    end

endmodule
